// ===== rtl/tts_pkg.sv =====
// Shared types and constants for the text token scanner.
package tts_pkg;

    // Default depth of the queue between front and back.
    localparam int TTS_QUEUE_DEPTH = 4;

    // Characters the scanner treats specially.
    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One result beat.
    typedef struct packed {
        logic [7:0] token_byte;
        logic       first_of_token;
        logic       last_of_token;
    } tok_t;

    // Up to two results produced by one input byte, in order.
    typedef struct packed {
        logic valid0;
        logic valid1;
        tok_t item0;
        tok_t item1;
    } tok_push_t;

endpackage

// ===== rtl/text_token_scanner.sv =====
// Top level of the text token scanner: front, queue and back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   s_      | in        | s_valid / s_ready  | s_text_byte[7:0]
//   m_      | out       | m_valid / m_ready  | m_token_byte, m_first_of_token, m_last_of_token
//
// One text byte is taken per cycle while s_ready is high; results reach m_ via the queue.
// The output port moves one beat per cycle while m_ready is high, so a brace closing a token
// (two results) takes an extra output beat, absorbed by the queue.
// s_ready is high while the queue has room for two results.
// Reset (aresetn low, synchronous) returns the scanner to the start of text and empties the queue.
// A stalled m_ready holds the output beat; the front keeps taking bytes until the queue fills.
module text_token_scanner #(
    parameter int QUEUE_DEPTH = tts_pkg::TTS_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_token_byte,
    output logic       m_first_of_token,
    output logic       m_last_of_token
);
    import tts_pkg::*;

    tok_push_t push;
    tok_t      head;
    tok_t      m_item;
    logic      room;
    logic      head_valid;
    logic      pop;
    logic      accept;

    assign s_ready = room;
    assign accept  = s_valid && room;

    tts_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .text_byte (s_text_byte),
        .accept    (accept),
        .push      (push)
    );

    tts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    assign m_token_byte     = m_item.token_byte;
    assign m_first_of_token = m_item.first_of_token;
    assign m_last_of_token  = m_item.last_of_token;

endmodule

// ===== rtl/tts_front.sv =====
// Front part: accepts text bytes, runs the scanning state and emits token results.
module tts_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         text_byte,
    input  logic               accept,
    output tts_pkg::tok_push_t push
);
    import tts_pkg::*;

    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_SKIP    = 2'd1;
    localparam logic [1:0] PH_TOKEN   = 2'd2;
    localparam logic [1:0] PH_COMMENT = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic       pws_reg, pws_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_valid_reg, held_valid_next;
    logic       held_first_reg, held_first_next;

    logic is_brace, is_plain, is_skip, is_term, is_eol;
    tok_push_t res;

    always_comb begin
        is_brace = (text_byte == CH_LBRACE) || (text_byte == CH_RBRACE);
        is_plain = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                   (text_byte == CH_CR) || (text_byte == CH_LF) ||
                   (text_byte == CH_COMMA) || (text_byte == CH_SEMI) ||
                   (text_byte == CH_QUOTE);
        is_skip  = is_plain || (text_byte == CH_SLASH);
        is_term  = is_plain || is_brace;
        is_eol   = (text_byte == CH_CR) || (text_byte == CH_LF);
    end

    always_comb begin
        phase_next      = phase_reg;
        pws_next        = pws_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        res             = '0;

        if (text_byte == CH_END) begin
            // Flush the held byte and return to the start position.
            res.valid0      = held_valid_reg;
            res.item0       = '{held_char_reg, held_first_reg, 1'b1};
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            held_char_next  = '0;
            phase_next      = PH_START;
            pws_next        = 1'b0;
        end else begin
            unique case (phase_reg) inside
                PH_TOKEN: begin
                    if (is_term) begin
                        held_valid_next = 1'b0;
                        held_first_next = 1'b0;
                        pws_next        = 1'b0;
                        if (held_valid_reg) begin
                            res.valid0 = 1'b1;
                            res.item0  = '{held_char_reg, held_first_reg, 1'b1};
                            if (is_brace) begin
                                res.valid1 = 1'b1;
                                res.item1  = '{text_byte, 1'b1, 1'b1};
                            end
                        end else if (is_brace) begin
                            res.valid0 = 1'b1;
                            res.item0  = '{text_byte, 1'b1, 1'b1};
                        end
                        phase_next = is_brace ? PH_START : PH_SKIP;
                    end else begin
                        res.valid0      = held_valid_reg;
                        res.item0       = '{held_char_reg, held_first_reg, 1'b0};
                        held_char_next  = text_byte;
                        held_first_next = ~held_valid_reg;
                        held_valid_next = 1'b1;
                    end
                end
                PH_COMMENT: begin
                    if (is_eol) begin
                        phase_next = PH_SKIP;
                        pws_next   = 1'b0;
                    end
                end
                PH_SKIP, PH_START: begin
                    if ((phase_reg == PH_SKIP) && (text_byte == CH_SLASH)) begin
                        // Second counting slash opens a comment.
                        phase_next = pws_reg ? PH_COMMENT : PH_SKIP;
                        pws_next   = ~pws_reg;
                    end else if (is_skip) begin
                        phase_next = PH_SKIP;
                        pws_next   = 1'b0;
                    end else begin
                        pws_next = 1'b0;
                        if (is_brace) begin
                            res.valid0 = 1'b1;
                            res.item0  = '{text_byte, 1'b1, 1'b1};
                            phase_next = PH_START;
                        end else begin
                            held_char_next  = text_byte;
                            held_first_next = 1'b1;
                            held_valid_next = 1'b1;
                            phase_next      = PH_TOKEN;
                        end
                    end
                end
                default: begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    assign push = accept ? res : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            pws_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            held_char_reg  <= '0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            pws_reg        <= pws_next;
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            held_char_reg  <= held_char_next;
        end
    end

    // A pending slash exists only while skipping separators.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pws_reg |-> (phase_reg == PH_SKIP))
        else $error("slash pending outside skip phase");

    // A token in progress always has its held byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TOKEN) |-> held_valid_reg)
        else $error("token phase without held byte");

    // The held byte exists only inside a token.
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> (phase_reg == PH_TOKEN))
        else $error("held byte outside token phase");

endmodule

// ===== rtl/tts_queue.sv =====
// Short queue between front and back: up to two writes and one read per cycle.
module tts_queue #(
    parameter int DEPTH = tts_pkg::TTS_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tts_pkg::tok_push_t push,
    output logic               room,
    output logic               head_valid,
    output tts_pkg::tok_t      head,
    input  logic               pop
);
    import tts_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tok_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_p1, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_push;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        wr_ptr_p1   = ptr_inc(wr_ptr_reg);
        n_push      = CW'(push.valid0) + CW'(push.valid1);
        wr_ptr_next = push.valid1 ? ptr_inc(wr_ptr_p1) :
                      (push.valid0 ? wr_ptr_p1 : wr_ptr_reg);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + n_push - CW'(pop);
    end

    assign room       = (count_reg <= CW'(DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            mem_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.valid1) begin
            mem_reg[wr_ptr_p1] <= push.item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue overfilled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid1 |-> push.valid0)
        else $error("second slot written without first");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid0 |-> room)
        else $error("push without room");

endmodule

// ===== rtl/tts_back.sv =====
// Back part: moves queued results into the output register.
module tts_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  tts_pkg::tok_t head,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output tts_pkg::tok_t m_item
);
    import tts_pkg::*;

    logic out_valid_reg;
    tok_t out_item_reg;

    // Load a new beat when the register is empty or is being taken.
    assign pop = head_valid && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_item_reg <= head;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
